@@ hdl/i2cms_pkg.sv @@
package i2cms_pkg;

    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_ACK   = 3'd5;

    localparam logic [2:0] ACT_TICK = 3'd0;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sda_is_input;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack;
    } res_t;

endpackage

@@ hdl/i2cms_seq.sv @@
module i2cms_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic [2:0]      action,
    input  logic [7:0]      data_byte,
    input  logic            sda_in,
    output i2cms_pkg::res_t res_next
);
    import i2cms_pkg::*;

    logic [2:0] op_reg, op_next;
    logic [5:0] step_reg, step_next;
    logic [2:0] wait_reg, wait_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       rel_reg, rel_next;
    logic       ack_reg, ack_next;
    logic [7:0] rx_reg, rx_next;
    logic       done;

    always_comb
    begin
        logic       run;
        logic [5:0] k;
        logic [2:0] wdec;
        logic [2:0] seg_wait;

        op_next    = op_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rel_next   = rel_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        run        = 1'b0;
        k          = step_reg;
        wdec       = wait_reg;
        seg_wait   = 3'd0;

        if (op_reg == OP_IDLE)
        begin
            if (action >= OP_START && action <= OP_ACK)
            begin
                op_next   = action;
                step_next = 6'd0;
                k         = 6'd0;
                run       = 1'b1;
                if (action == OP_WRITE)
                begin
                    shift_next = data_byte;
                end
            end
        end
        else if (action == ACT_TICK)
        begin
            if (wait_reg != 3'd0)
            begin
                wdec = wait_reg - 3'd1;
            end
            wait_next = wdec;
            if (wdec == 3'd0)
            begin
                k         = step_reg + 6'd1;
                step_next = k;
                run       = 1'b1;
            end
        end

        if (run)
        begin
            case (op_next)
                OP_START:
                begin
                    if (k == 6'd0)
                    begin
                        rel_next = 1'b0;
                        sda_next = 1'b1;
                        seg_wait = 3'd1;
                    end
                    else if (k == 6'd1)
                    begin
                        scl_next = 1'b1;
                        seg_wait = 3'd5;
                    end
                    else if (k == 6'd2)
                    begin
                        sda_next = 1'b0;
                        seg_wait = 3'd5;
                    end
                    else if (k == 6'd3)
                    begin
                        scl_next = 1'b0;
                        seg_wait = 3'd2;
                    end
                end
                OP_STOP:
                begin
                    if (k == 6'd0)
                    begin
                        rel_next = 1'b0;
                        sda_next = 1'b0;
                        seg_wait = 3'd1;
                    end
                    else if (k == 6'd1)
                    begin
                        scl_next = 1'b1;
                        seg_wait = 3'd5;
                    end
                    else if (k == 6'd2)
                    begin
                        sda_next = 1'b1;
                        seg_wait = 3'd4;
                    end
                end
                OP_ACK:
                begin
                    if (k == 6'd0)
                    begin
                        rel_next = 1'b0;
                        sda_next = data_byte[0];
                        seg_wait = 3'd3;
                    end
                    else if (k == 6'd1)
                    begin
                        scl_next = 1'b1;
                        seg_wait = 3'd5;
                    end
                    else if (k == 6'd2)
                    begin
                        scl_next = 1'b0;
                        seg_wait = 3'd2;
                    end
                end
                OP_WRITE:
                begin
                    if (k < 6'd16)
                    begin
                        if (!k[0])
                        begin
                            if (k == 6'd0)
                            begin
                                rel_next = 1'b0;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                            end
                            sda_next   = shift_next[7];
                            shift_next = {shift_next[6:0], 1'b0};
                            seg_wait   = 3'd1;
                        end
                        else
                        begin
                            scl_next = 1'b1;
                            seg_wait = 3'd5;
                        end
                    end
                    else if (k == 6'd16)
                    begin
                        scl_next = 1'b0;
                        seg_wait = 3'd2;
                    end
                    else if (k == 6'd17)
                    begin
                        rel_next = 1'b1;
                        seg_wait = 3'd2;
                    end
                    else if (k == 6'd18)
                    begin
                        scl_next = 1'b1;
                        seg_wait = 3'd3;
                    end
                    else if (k == 6'd19)
                    begin
                        ack_next = ~sda_in;
                        scl_next = 1'b0;
                        seg_wait = 3'd2;
                    end
                end
                OP_READ:
                begin
                    if (k == 6'd0)
                    begin
                        rel_next   = 1'b1;
                        shift_next = 8'd0;
                        seg_wait   = 3'd1;
                    end
                    else if (k < 6'd32)
                    begin
                        case (k[1:0])
                            2'd0: seg_wait = 3'd1;
                            2'd1:
                            begin
                                scl_next = 1'b0;
                                seg_wait = 3'd5;
                            end
                            2'd2:
                            begin
                                scl_next = 1'b1;
                                seg_wait = 3'd3;
                            end
                            default:
                            begin
                                shift_next = {shift_next[6:0], sda_in};
                                seg_wait   = 3'd2;
                            end
                        endcase
                    end
                    else if (k == 6'd32)
                    begin
                        scl_next = 1'b0;
                        seg_wait = 3'd2;
                    end
                    else
                    begin
                        rx_next = shift_next;
                    end
                end
                default: seg_wait = 3'd0;
            endcase

            wait_next = seg_wait;
            if (seg_wait == 3'd0)
            begin
                op_next   = OP_IDLE;
                step_next = 6'd0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            step_reg  <= 6'd0;
            wait_reg  <= 3'd0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rel_reg   <= 1'b0;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (adv)
        begin
            op_reg    <= op_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rel_reg   <= rel_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    assign res_next.scl          = scl_next;
    assign res_next.sda          = sda_next;
    assign res_next.sda_is_input = rel_next;
    assign res_next.busy         = (op_next != OP_IDLE);
    assign res_next.done         = done;
    assign res_next.rx_byte      = rx_next;
    assign res_next.ack          = ack_next;

endmodule

@@ hdl/i2c_master_byte_sequencer.sv @@
// An accepted item sits in the input register, its result in the result register.
// Throughput: one item per cycle while res_stall is low; the line state updates once per
// item in the sequencer stage, between the input register and the result register.
// Reset (rst_n low, asynchronous): sequencer idle with SCL and SDA high, SDA in output
// mode, ack and rx byte cleared, both pipeline stages empty; result register not reset.
module i2c_master_byte_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    input  logic       sda_in,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       scl_out,
    output logic       sda_out,
    output logic       sda_is_input,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_seen
);
    import i2cms_pkg::*;

    logic       s1_valid_reg;
    logic [2:0] act_reg;
    logic [7:0] data_reg;
    logic       sdai_reg;
    logic       res_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic       res_free;
    logic       s1_adv;
    logic       cmd_fire;

    assign res_free  = ~res_valid_reg | ~res_stall;
    assign s1_adv    = s1_valid_reg & res_free;
    assign cmd_stall = s1_valid_reg & ~res_free;
    assign cmd_fire  = cmd_valid & ~cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            act_reg  <= action;
            data_reg <= data_byte;
            sdai_reg <= sda_in;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    i2cms_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (s1_adv),
        .action    (act_reg),
        .data_byte (data_reg),
        .sda_in    (sdai_reg),
        .res_next  (res_next)
    );

    assign res_valid    = res_valid_reg;
    assign scl_out      = res_reg.scl;
    assign sda_out      = res_reg.sda;
    assign sda_is_input = res_reg.sda_is_input;
    assign busy_res     = res_reg.busy;
    assign done_res     = res_reg.done;
    assign rx_byte      = res_reg.rx_byte;
    assign ack_seen     = res_reg.ack;

`ifndef ASSERT_OFF
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg)
        else $error("cmd_stall raised with empty input stage");

    a_adv_fills_res: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> res_valid_reg)
        else $error("advanced item did not reach result register");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done) |-> !res_reg.busy)
        else $error("done reported while still busy");

    a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> s1_valid_reg)
        else $error("accepted item lost from input stage");
`endif

endmodule

@@ tb/i2c_master_byte_sequencer_tb.sv @@
module i2c_master_byte_sequencer_tb;
    import i2cms_pkg::*;

    localparam logic [2:0] ACT_RSV6 = 3'd6;
    localparam logic [2:0] ACT_RSV7 = 3'd7;
    localparam int RAND_ITEMS   = 1300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 8;

    localparam res_t IDLE_LINES = '{scl: 1'b1, sda: 1'b1, sda_is_input: 1'b0, busy: 1'b0,
                                    done: 1'b0, rx_byte: 8'h00, ack: 1'b0};
    localparam res_t START_LINES = '{scl: 1'b1, sda: 1'b1, sda_is_input: 1'b0, busy: 1'b1,
                                     done: 1'b0, rx_byte: 8'h00, ack: 1'b0};

    typedef struct {
        logic [2:0] act;
        logic [7:0] dat;
        logic       sda;
        int         reps;
        bit         typed;
        res_t       want;
    } step_row_t;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       sda_in;
    logic       res_valid;
    logic       res_stall;
    logic       scl_out;
    logic       sda_out;
    logic       sda_is_input;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;

    // line state as the sequencer should hold it
    logic [2:0] p_op    = OP_IDLE;
    logic [5:0] p_step  = '0;
    logic [2:0] p_wait  = '0;
    logic [7:0] p_shift = '0;
    logic       p_scl   = 1'b1;
    logic       p_sda   = 1'b1;
    logic       p_rel   = 1'b0;
    logic       p_ack   = 1'b0;
    logic [7:0] p_rx    = '0;

    res_t expected_lines_q[$];
    int   mismatches = 0;
    int   quiet = 0;
    bit   tx_burst = 1'b0;

    step_row_t plan [12] = '{
        '{ACT_TICK, 8'hFF, 1'b1, 1,  1'b1, IDLE_LINES},
        '{ACT_RSV6, 8'hFF, 1'b1, 1,  1'b1, IDLE_LINES},
        '{ACT_RSV7, 8'h00, 1'b0, 1,  1'b1, IDLE_LINES},
        '{OP_START, 8'h00, 1'b0, 1,  1'b1, START_LINES},
        '{OP_STOP,  8'h00, 1'b0, 1,  1'b0, '0},
        '{OP_WRITE, 8'hFF, 1'b1, 1,  1'b0, '0},
        '{OP_READ,  8'h00, 1'b1, 1,  1'b0, '0},
        '{OP_ACK,   8'h01, 1'b0, 1,  1'b0, '0},
        '{ACT_RSV6, 8'h00, 1'b0, 1,  1'b0, '0},
        '{ACT_TICK, 8'h00, 1'b1, 13, 1'b0, '0},
        '{OP_ACK,   8'hFF, 1'b0, 1,  1'b0, '0},
        '{ACT_TICK, 8'hAA, 1'b0, 10, 1'b0, '0}
    };

    i2c_master_byte_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .action       (action),
        .data_byte    (data_byte),
        .sda_in       (sda_in),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .sda_is_input (sda_is_input),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .ack_seen     (ack_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // applies the level changes that open the current segment, returns its wait
    function automatic logic [2:0] open_segment(input logic s, input logic [7:0] d);
        logic [5:0] k;
        k = p_step;
        case (p_op)
            OP_START:
            begin
                if (k == 0) begin p_rel = 1'b0; p_sda = 1'b1; return 3'd1; end
                if (k == 1) begin p_scl = 1'b1; return 3'd5; end
                if (k == 2) begin p_sda = 1'b0; return 3'd5; end
                if (k == 3) begin p_scl = 1'b0; return 3'd2; end
            end
            OP_STOP:
            begin
                if (k == 0) begin p_rel = 1'b0; p_sda = 1'b0; return 3'd1; end
                if (k == 1) begin p_scl = 1'b1; return 3'd5; end
                if (k == 2) begin p_sda = 1'b1; return 3'd4; end
            end
            OP_ACK:
            begin
                if (k == 0) begin p_rel = 1'b0; p_sda = d[0]; return 3'd3; end
                if (k == 1) begin p_scl = 1'b1; return 3'd5; end
                if (k == 2) begin p_scl = 1'b0; return 3'd2; end
            end
            OP_WRITE:
            begin
                if (k < 16) begin
                    if (!k[0]) begin
                        if (k == 0)
                            p_rel = 1'b0;
                        else
                            p_scl = 1'b0;
                        p_sda = p_shift[7];
                        p_shift = {p_shift[6:0], 1'b0};
                        return 3'd1;
                    end
                    p_scl = 1'b1;
                    return 3'd5;
                end
                if (k == 16) begin p_scl = 1'b0; return 3'd2; end
                if (k == 17) begin p_rel = 1'b1; return 3'd2; end
                if (k == 18) begin p_scl = 1'b1; return 3'd3; end
                if (k == 19) begin p_ack = !s; p_scl = 1'b0; return 3'd2; end
            end
            OP_READ:
            begin
                if (k == 0) begin p_rel = 1'b1; p_shift = '0; return 3'd1; end
                if (k < 32) begin
                    case (k[1:0])
                        2'd0: return 3'd1;
                        2'd1: begin p_scl = 1'b0; return 3'd5; end
                        2'd2: begin p_scl = 1'b1; return 3'd3; end
                        default: begin p_shift = {p_shift[6:0], s}; return 3'd2; end
                    endcase
                end
                if (k == 32) begin p_scl = 1'b0; return 3'd2; end
                p_rx = p_shift;
            end
            default: ;
        endcase
        return 3'd0;
    endfunction

    function automatic res_t advance_lines(input logic [2:0] a, input logic [7:0] d,
                                           input logic s);
        res_t r;
        logic fin;
        fin = 1'b0;
        if (p_op == OP_IDLE) begin
            if (a >= OP_START && a <= OP_ACK) begin
                p_op = a;
                p_step = '0;
                if (a == OP_WRITE)
                    p_shift = d;
                p_wait = open_segment(s, d);
                if (p_wait == 0) begin
                    p_op = OP_IDLE;
                    fin = 1'b1;
                end
            end
        end else if (a == ACT_TICK) begin
            if (p_wait > 0)
                p_wait = p_wait - 3'd1;
            if (p_wait == 0) begin
                p_step = p_step + 6'd1;
                p_wait = open_segment(s, d);
                if (p_wait == 0) begin
                    p_op = OP_IDLE;
                    p_step = '0;
                    fin = 1'b1;
                end
            end
        end
        r.scl = p_scl;
        r.sda = p_sda;
        r.sda_is_input = p_rel;
        r.busy = (p_op != OP_IDLE);
        r.done = fin;
        r.rx_byte = p_rx;
        r.ack = p_ack;
        return r;
    endfunction

    task automatic send_item(input logic [2:0] a, input logic [7:0] d, input logic s,
                             input bit typed, input res_t want);
        int gap;
        res_t pred;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        action    <= a;
        data_byte <= d;
        sda_in    <= s;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pred = advance_lines(a, d, s);
        expected_lines_q.push_back(typed ? want : pred);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // sender
    initial
    begin
        int sent;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        action    <= ACT_TICK;
        data_byte <= '0;
        sda_in    <= 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            repeat (plan[i].reps)
                send_item(plan[i].act, plan[i].dat, plan[i].sda, plan[i].typed, plan[i].want);
        end

        // mostly complete command sequences, with ignored noise and loose items
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8) begin
                while (p_op != OP_IDLE)
                begin
                    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
                    sent++;
                end
                send_item(3'($urandom_range(OP_START, OP_ACK)), 8'($urandom), 1'($urandom),
                          1'b0, '0);
                sent++;
                while (p_op != OP_IDLE)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                                  1'b0, '0);
                    send_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 20))
                begin
                    send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'b0, '0);
                    sent++;
                end
            end
        end
        cmd_valid <= 1'b0;

        while (expected_lines_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver
    initial
    begin
        int gap;
        int taken;
        bit rx_burst;
        res_t got;
        res_t want;
        taken = 0;
        rx_burst = 1'b0;
        res_stall <= 1'b1;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 8);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            taken++;
            got = '{scl_out, sda_out, sda_is_input, busy_res, done_res, rx_byte, ack_seen};
            if (expected_lines_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %0h", $time, got);
                mismatches++;
            end else begin
                want = expected_lines_q.pop_front();
                check_field("scl_out", 8'(want.scl), 8'(got.scl));
                check_field("sda_out", 8'(want.sda), 8'(got.sda));
                check_field("sda_is_input", 8'(want.sda_is_input), 8'(got.sda_is_input));
                check_field("busy_res", 8'(want.busy), 8'(got.busy));
                check_field("done_res", 8'(want.done), 8'(got.done));
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("ack_seen", 8'(want.ack), 8'(got.ack));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
